// ===== rtl/murmur2_64b_byte_stream_hash_macros.svh =====
// Assertion macros for the MurmurHash64B byte stream hasher.
`ifndef MURMUR2_64B_BYTE_STREAM_HASH_MACROS_SVH
`define MURMUR2_64B_BYTE_STREAM_HASH_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MH_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define MH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MH_ASSERT(lbl, cond)
`define MH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/mh64b_pkg.sv =====
// Types and constants shared by the MurmurHash64B hasher modules.
`timescale 1ns / 1ps
package mh64b_pkg;

  localparam logic [31:0] MIX_MUL = 32'h5bd1e995;
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic        init;
    logic [31:0] init_val;
    logic        mix;
    logic        odd;
    logic [31:0] word;
    logic        fin;
    logic        tail_en;
    logic [23:0] tail;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic       full;
    logic [1:0] count;
  } q_status_t;

endpackage

// ===== rtl/mh64b_front.sv =====
// Front end: packs bytes into words and turns items into back-end commands.
`timescale 1ns / 1ps
module mh64b_front
  import mh64b_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        first_item,
  input  logic        last_item,
  input  logic [31:0] message_length,
  input  logic [31:0] hash_seed,
  output logic        push,
  output cmd_t        cmd
);

  logic [23:0] partial_word;
  logic [1:0]  bytes_in_word;
  logic        odd_word;
  logic [23:0] partial_word_next;
  logic [1:0]  bytes_in_word_next;
  logic        odd_word_next;
  logic [23:0] pw_eff;
  logic [1:0]  bc_eff;
  logic        odd_eff;
  logic        word_done;

  always_comb begin
    pw_eff = first_item ? 24'd0 : partial_word;
    bc_eff = first_item ? 2'd0 : bytes_in_word;
    odd_eff = first_item ? 1'b0 : odd_word;
    word_done = byte_valid && (bc_eff == 2'd3);
    partial_word_next = pw_eff;
    bytes_in_word_next = bc_eff;
    odd_word_next = odd_eff;
    if (byte_valid) begin
      if (word_done) begin
        partial_word_next = 24'd0;
        bytes_in_word_next = 2'd0;
        odd_word_next = ~odd_eff;
      end else begin
        partial_word_next = pw_eff | (24'(data_byte) << {bc_eff, 3'b000});
        bytes_in_word_next = bc_eff + 2'd1;
      end
    end
    cmd.init = first_item;
    cmd.init_val = hash_seed ^ message_length;
    cmd.mix = word_done;
    cmd.odd = odd_eff;
    cmd.word = {data_byte, pw_eff};
    cmd.fin = last_item;
    cmd.tail_en = (bytes_in_word_next != 2'd0);
    cmd.tail = partial_word_next;
    push = accept && (first_item || word_done || last_item);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_word <= 24'd0;
      bytes_in_word <= 2'd0;
      odd_word <= 1'b0;
    end else if (accept) begin
      if (last_item) begin
        partial_word <= 24'd0;
        bytes_in_word <= 2'd0;
        odd_word <= 1'b0;
      end else begin
        partial_word <= partial_word_next;
        bytes_in_word <= bytes_in_word_next;
        odd_word <= odd_word_next;
      end
    end
  end

endmodule

// ===== rtl/mh64b_queue.sv =====
// Two-entry command queue between front end and back end.
`timescale 1ns / 1ps
module mh64b_queue
  import mh64b_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head_cmd,
  output q_status_t status
);

  cmd_t       mem [Q_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head_cmd = mem[rd_ptr];
  assign status.valid = (count != 2'd0);
  assign status.full = (count == 2'(Q_DEPTH));
  assign status.count = count;

endmodule

// ===== rtl/mh64b_back.sv =====
// Back end: word mixing and final mix over one shared 32x32 multiplier.
`timescale 1ns / 1ps
module mh64b_back
  import mh64b_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_high,
  output logic [31:0] hash_low
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_W1   = 3'd1;
  localparam logic [2:0] S_W2   = 3'd2;
  localparam logic [2:0] S_L    = 3'd3;
  localparam logic [2:0] S_T    = 3'd4;
  localparam logic [2:0] S_F1   = 3'd5;
  localparam logic [2:0] S_F2   = 3'd6;
  localparam logic [2:0] S_F3   = 3'd7;

  logic [2:0]  state;
  logic        fin4;
  cmd_t        cmd;
  logic [31:0] acc;
  logic [31:0] lane_one;
  logic [31:0] lane_two;
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic        out_free;

  // fin4 marks the last final-mix round, which also loads the output
  assign pop = q_valid && (state == S_IDLE) && !fin4;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    if (fin4) begin
      mul_a = lane_two ^ (lane_one >> 19);
    end else begin
      case (state)
        S_W1:    mul_a = cmd.word;
        S_W2:    mul_a = acc ^ (acc >> 24);
        S_L:     mul_a = cmd.odd ? lane_two : lane_one;
        S_T:     mul_a = lane_two ^ {8'd0, cmd.tail};
        S_F1:    mul_a = lane_one ^ (lane_two >> 18);
        S_F2:    mul_a = lane_two ^ (lane_one >> 22);
        S_F3:    mul_a = lane_one ^ (lane_two >> 17);
        default: mul_a = 32'd0;
      endcase
    end
  end

  assign prod = mul_a * MIX_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin4 <= 1'b0;
      lane_one <= 32'd0;
      lane_two <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      // a transfer during fin4 is followed by the new result below
      if (out_valid && out_ready && !fin4) begin
        out_valid <= 1'b0;
      end
      if (fin4) begin
        if (out_free) begin
          hash_high <= lane_one;
          hash_low <= prod;
          out_valid <= 1'b1;
          lane_one <= 32'd0;
          lane_two <= 32'd0;
          fin4 <= 1'b0;
        end
      end else begin
        case (state)
          S_IDLE: begin
            if (pop) begin
              cmd <= q_cmd;
              if (q_cmd.init) begin
                lane_one <= q_cmd.init_val;
                lane_two <= 32'd0;
              end
              if (q_cmd.mix) begin
                state <= S_W1;
              end else if (q_cmd.fin) begin
                state <= S_T;
              end
            end
          end
          S_W1: begin
            acc <= prod;
            state <= S_W2;
          end
          S_W2: begin
            acc <= prod;
            state <= S_L;
          end
          S_L: begin
            if (cmd.odd) begin
              lane_two <= prod ^ acc;
            end else begin
              lane_one <= prod ^ acc;
            end
            state <= cmd.fin ? S_T : S_IDLE;
          end
          S_T: begin
            if (cmd.tail_en) begin
              lane_two <= prod;
            end
            state <= S_F1;
          end
          S_F1: begin
            lane_one <= prod;
            state <= S_F2;
          end
          S_F2: begin
            lane_two <= prod;
            state <= S_F3;
          end
          S_F3: begin
            lane_one <= prod;
            fin4 <= 1'b1;
            state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

// ===== rtl/murmur2_64b_byte_stream_hash.sv =====
// Top level of the MurmurHash64B byte stream hasher.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   data_byte, byte_valid, first_item,
//                                            last_item, message_length
//  out      output     out_valid / out_ready hash_high, hash_low
//  cfg      input      APB psel / penable    hash_seed at byte address 0
//
// Items enter one per cycle while the two-entry command queue has room.
// The back end shares one multiplier: a full word is mixed in states W1, W2 and L,
// and the final mix of a last item runs through T, F1, F2, F3 and the fin4 round.
// Reset (rst, synchronous) clears lanes, queue, gathered bytes and seed.
// in_ready drops when the queue is full; a stalled result holds the back end.
`timescale 1ns / 1ps
`include "murmur2_64b_byte_stream_hash_macros.svh"
module murmur2_64b_byte_stream_hash
  import mh64b_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        first_item,
  input  logic        last_item,
  input  logic [31:0] message_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_high,
  output logic [31:0] hash_low,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ADDR_HASH_SEED = 2'd0;

  logic [31:0] hash_seed;
  logic        accept;
  logic        push;
  logic        pop;
  cmd_t        push_cmd;
  cmd_t        head_cmd;
  q_status_t   q_status;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_HASH_SEED) ? hash_seed : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= 32'd0;
    end else if (psel && penable && pwrite && (paddr == ADDR_HASH_SEED)) begin
      hash_seed <= pwdata;
    end
  end

  assign in_ready = !q_status.full;
  assign accept = in_valid && in_ready;

  mh64b_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .first_item     (first_item),
    .last_item      (last_item),
    .message_length (message_length),
    .hash_seed      (hash_seed),
    .push           (push),
    .cmd            (push_cmd)
  );

  mh64b_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  mh64b_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_status.valid),
    .q_cmd     (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hash_high (hash_high),
    .hash_low  (hash_low)
  );

  `MH_ASSERT(a_no_overflow, !(push && q_status.full))
  `MH_ASSERT(a_pop_nonempty, !(pop && !q_status.valid))
  `MH_ASSERT_NEXT(a_count_up, push && !pop, q_status.count == $past(q_status.count) + 2'd1)

endmodule
